>>> sv/nksk_pkg.sv
// Package for the nearest-K sorted keep list: beat types, cell entry type
// and fixed field widths. No dependencies.
package nksk_pkg;

    localparam int KEY_WIDTH   = 32;
    localparam int TAG_WIDTH   = 16;
    localparam int IDX_WIDTH   = 3;
    localparam int COUNT_WIDTH = 16;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // One offer beat.
    typedef struct packed {
        logic [KEY_WIDTH-1:0] distance_key;
        logic [TAG_WIDTH-1:0] candidate_tag;
        logic                 first_of_frame;
        logic                 end_of_frame;
    } in_t;

    // One emitted slot beat.
    typedef struct packed {
        logic [IDX_WIDTH-1:0]   slot_index;
        logic                   slot_valid;
        logic [KEY_WIDTH-1:0]   slot_key;
        logic [TAG_WIDTH-1:0]   slot_tag;
        logic [COUNT_WIDTH-1:0] offered_count;
        logic                   last_slot;
    } out_t;

    // Contents of one list cell as seen by its neighbors.
    typedef struct packed {
        logic                 valid;
        logic [KEY_WIDTH-1:0] key;
        logic [TAG_WIDTH-1:0] tag;
    } entry_t;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic clear;
        logic rotate;
    } cell_ctrl_t;

endpackage

>>> sv/nksk_cell.sv
// One cell of the sorted keep list: holds one entry, decides locally
// whether a new key lands here, and shifts or rotates with its neighbors.
// Depends on nksk_pkg.
module nksk_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  nksk_pkg::cell_ctrl_t ctrl,
    input  nksk_pkg::entry_t    new_entry,
    input  nksk_pkg::entry_t    left_entry,
    input  logic                left_ins,
    input  nksk_pkg::entry_t    right_entry,
    output nksk_pkg::entry_t    entry,
    output logic                ins
);
    import nksk_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic [TAG_WIDTH-1:0] tag_next;
    logic                 valid_eff;

    // A clear on this beat empties the cell before the offer is placed.
    assign valid_eff = valid_reg & ~ctrl.clear;

    // The new key belongs here or earlier when the cell is empty or holds
    // a strictly larger key, so equal keys keep their arrival order.
    assign ins = ~valid_eff | (new_entry.key < key_reg);

    assign entry.valid = valid_eff;
    assign entry.key   = key_reg;
    assign entry.tag   = tag_reg;

    // Next contents: rotate during readout, otherwise shift or take the offer.
    // With no insert and no rotate there is no clear, so the cell holds.
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        priority if (ctrl.rotate)
        begin
            valid_next = right_entry.valid;
            key_next   = right_entry.key;
            tag_next   = right_entry.tag;
        end
        else if (ctrl.insert && ins && left_ins)
        begin
            valid_next = left_entry.valid;
            key_next   = left_entry.key;
            tag_next   = left_entry.tag;
        end
        else if (ctrl.insert && ins)
        begin
            valid_next = new_entry.valid;
            key_next   = new_entry.key;
            tag_next   = new_entry.tag;
        end
        else
        begin
            valid_next = valid_eff;
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Key and tag payload.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

>>> sv/nearest_k_sorted_keep.sv
// Top level of the nearest-K sorted keep list: a row of nksk_cell cells,
// the offer counter and the readout sequencer. Depends on nksk_pkg, nksk_cell.
// Timing: an offer is applied at its accept edge; after an end_of_frame beat
//   the slots follow on strobe one after another, slot 0 first.
// Throughput: one offer per cycle while busy is low; an end_of_frame beat starts
//   a readout; busy holds while the cells rotate their contents past slot 0.
// Reset: list empty, offer count zero, no readout running; results cannot stall.
module nearest_k_sorted_keep #(
    parameter int KEEP_DEPTH = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  nksk_pkg::in_t  item,
    output logic           strobe,
    output nksk_pkg::out_t result
);
    import nksk_pkg::*;

    localparam int SLOT_W = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(KEEP_DEPTH - 1);

    typedef enum logic {ST_IDLE, ST_EMIT} state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SLOT_W-1:0]      slot_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] count_base;
    logic                   accept;
    cell_ctrl_t             ctrl;
    entry_t                 new_entry;
    entry_t                 cell_entry [KEEP_DEPTH];
    logic                   cell_ins   [KEEP_DEPTH];

    assign accept = start & ~busy;
    assign busy   = (state_reg == ST_EMIT);

    assign ctrl.insert = accept;
    assign ctrl.clear  = accept & item.first_of_frame;
    assign ctrl.rotate = busy;

    assign new_entry.valid = 1'b1;
    assign new_entry.key   = item.distance_key;
    assign new_entry.tag   = item.candidate_tag;

    // Chain of cells; the last cell wraps to the first for readout rotation.
    for (genvar i = 0; i < KEEP_DEPTH; i++)
    begin : g_cell
        entry_t left_entry;
        logic   left_ins;

        if (i == 0)
        begin : g_head
            assign left_entry = '0;
            assign left_ins   = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_ins   = cell_ins[i-1];
        end

        nksk_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .left_ins    (left_ins),
            .right_entry (cell_entry[(i + 1) % KEEP_DEPTH]),
            .entry       (cell_entry[i]),
            .ins         (cell_ins[i])
        );
    end

    // Saturating offer counter, restarted by a clear.
    always_comb
    begin
        count_base = item.first_of_frame ? '0 : count_reg;
        count_next = count_reg;
        if (accept)
        begin
            count_next = (count_base == COUNT_MAX) ? count_base : count_base + 1'b1;
        end
    end

    // Readout sequencer.
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                slot_next = '0;
                if (accept && item.end_of_frame)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SLOT_LAST)
                begin
                    state_next = ST_IDLE;
                    slot_next  = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                slot_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            count_reg <= count_next;
        end
    end

    // Result beat comes straight from the head cell; empty slots read as zero.
    assign strobe               = busy;
    assign result.slot_index    = IDX_WIDTH'(slot_reg);
    assign result.slot_valid    = cell_entry[0].valid;
    assign result.slot_key      = cell_entry[0].valid ? cell_entry[0].key : '0;
    assign result.slot_tag      = cell_entry[0].valid ? cell_entry[0].tag : '0;
    assign result.offered_count = count_reg;
    assign result.last_slot     = (slot_reg == SLOT_LAST);

    // An end-of-frame offer starts the readout at slot 0 on the next cycle.
    a_emit_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.end_of_frame |=> strobe && (slot_reg == '0))
        else $error("readout did not start after end of frame");

    // The final slot ends the readout.
    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last_slot |=> !busy)
        else $error("readout ran past the last slot");

    // Within a readout the reported count holds and slots stay consecutive.
    a_emit_steady: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_slot |=>
            strobe && $stable(result.offered_count) && (slot_reg == $past(slot_reg) + 1'b1))
        else $error("readout beats not consecutive");

    // Kept entries form a prefix: once an empty slot appears, the rest are empty.
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.slot_valid && !result.last_slot |=> !result.slot_valid)
        else $error("valid entry after an empty slot");

    // A clearing offer leaves exactly one counted offer.
    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.first_of_frame |=> count_reg == COUNT_WIDTH'(1))
        else $error("offer count wrong after clear");

endmodule
